@@ hw/rtl/pir_motion_qualifier_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PIR_MOTION_QUALIFIER_ASSERT_SVH
`define PIR_MOTION_QUALIFIER_ASSERT_SVH

// same-cycle implication
`define PMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pmq_pkg.sv @@
package pmq_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned STABLE_W = 8;
    localparam int unsigned WIN_W    = 20;
    localparam int unsigned HIGH_W   = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(10);
    localparam logic [STABLE_W-1:0] STABLE_RST  = STABLE_W'(3);
    localparam logic [WIN_W-1:0]    STARTUP_RST = WIN_W'(30000);
    localparam logic [HIGH_W-1:0]   HIGH_RST    = HIGH_W'(200);
    localparam logic [WIN_W-1:0]    LOCKOUT_RST = WIN_W'(2000);

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_CONSUME = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_PERIOD = 3'd0,
        CFG_STABLE_SAMPLES = 3'd1,
        CFG_STARTUP_IGNORE = 3'd2,
        CFG_VALID_HIGH = 3'd3,
        CFG_LOCKOUT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic stable;
        logic changed;
    } deb_status_t;

endpackage

@@ hw/rtl/pmq_debounce.sv @@
module pmq_debounce
    import pmq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_en,
    input  logic                raw,
    input  logic [STABLE_W-1:0] stable_samples,
    output deb_status_t         status
);

    logic                prev_raw_reg, prev_raw_next;
    logic                stable_reg, stable_next;
    logic [STABLE_W-1:0] count_reg, count_next;
    logic [STABLE_W:0]   count_inc;
    logic                changed;

    assign count_inc = {1'b0, count_reg} + (STABLE_W+1)'(1);

    always_comb
    begin
        prev_raw_next = prev_raw_reg;
        stable_next   = stable_reg;
        count_next    = count_reg;
        changed       = 1'b0;
        if (sample_en)
        begin
            if (raw != prev_raw_reg)
            begin
                prev_raw_next = raw;
                count_next    = '0;
            end
            else if (count_reg < stable_samples)
            begin
                count_next = count_inc[STABLE_W-1:0];
                if ((count_inc >= {1'b0, stable_samples}) && (stable_reg != raw))
                begin
                    stable_next = raw;
                    changed     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= 1'b0;
            stable_reg   <= 1'b0;
            count_reg    <= STABLE_RST;
        end
        else
        begin
            prev_raw_reg <= prev_raw_next;
            stable_reg   <= stable_next;
            count_reg    <= count_next;
        end
    end

    assign status.stable  = stable_next;
    assign status.changed = changed;

endmodule

@@ hw/rtl/pir_motion_qualifier.sv @@
// pir_motion_qualifier
// Input channel (in_valid/in_ready): one word per millisecond tick (action 0,
// pin_level sampled) or per consume request (action 1, pin_level ignored).
// Output channel (out_valid/out_ready): exactly one word per input word, in
// order: is_ready, filtered_level and, for a consume, the motion_event latch.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, one
// register per write; unknown indexes are dropped. Write only while idle.
// Latency: the result word is valid the cycle after the input word is taken.
// Throughput: one word per cycle when not stalled; the tick logic is a short
// chain off the state registers (sample period subtract and compare, debounce
// count compare, then the age and lockout checks), and the result register
// lets a new word in while the previous result is being taken.
// Stall: while out_valid is high and out_ready low, the result word holds and
// in_ready drops; nothing is lost.
// Reset: now_reg starts at 1, other time registers clear, the pin is taken as
// low, the debounce count starts at STABLE_RST, config returns to its defaults.
module pir_motion_qualifier
    import pmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic                  pin_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_ready,
    output logic                  filtered_level,
    output logic                  motion_event,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PERIOD_W-1:0] period_reg;
    logic [STABLE_W-1:0] stable_samples_reg;
    logic [WIN_W-1:0]    startup_reg;
    logic [HIGH_W-1:0]   valid_high_reg;
    logic [WIN_W-1:0]    lockout_reg;

    // now_reg holds the time the next tick will see
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] last_sample_reg, last_sample_next;
    logic [TIME_W-1:0] rise_time_reg, rise_time_next;
    logic [TIME_W-1:0] lock_until_reg, lock_until_next;
    logic              ready_reg, ready_next;
    logic              armed_reg, armed_next;
    logic              latch_reg, latch_next;
    logic              pending_reg, pending_next;

    logic              out_valid_reg;
    logic              is_ready_reg, filtered_reg, event_reg;

    logic              accept;
    logic              tick;
    logic              sample_en;
    logic [TIME_W-1:0] since_sample;
    logic [TIME_W-1:0] since_rise;
    logic [TIME_W-1:0] since_lock;
    logic              pend_mid;
    logic              event_now;
    deb_status_t       deb;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign tick      = accept && (action == ACT_TICK);
    assign cfg_ready = 1'b1;

    assign since_sample = now_reg - last_sample_reg;
    assign since_lock   = now_reg - lock_until_reg;
    assign sample_en    = tick && (since_sample >= TIME_W'(period_reg));

    pmq_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_en      (sample_en),
        .raw            (pin_level),
        .stable_samples (stable_samples_reg),
        .status         (deb)
    );

    // a rise recorded on this sample has zero age
    assign since_rise = (deb.changed && deb.stable) ? '0 : (now_reg - rise_time_reg);

    always_comb
    begin
        now_next         = now_reg;
        last_sample_next = last_sample_reg;
        rise_time_next   = rise_time_reg;
        lock_until_next  = lock_until_reg;
        ready_next       = ready_reg;
        armed_next       = armed_reg;
        latch_next       = latch_reg;
        pending_next     = pending_reg;
        pend_mid         = pending_reg;
        event_now        = 1'b0;

        if (accept && (action == ACT_CONSUME))
        begin
            event_now  = latch_reg;
            latch_next = 1'b0;
        end

        if (tick)
        begin
            now_next = now_reg + TIME_W'(1);
        end

        if (sample_en)
        begin
            last_sample_next = now_reg;
            if (!ready_reg)
            begin
                if (now_reg >= TIME_W'(startup_reg))
                begin
                    ready_next   = 1'b1;
                    latch_next   = 1'b0;
                    pending_next = 1'b0;
                    armed_next   = !deb.stable;
                end
            end
            else if (!armed_reg)
            begin
                if (!deb.stable)
                begin
                    armed_next = 1'b1;
                end
            end
            else
            begin
                if (deb.changed)
                begin
                    pend_mid = deb.stable;
                    if (deb.stable)
                    begin
                        rise_time_next = now_reg;
                    end
                end
                pending_next = pend_mid;
                if (!since_lock[TIME_W-1] && deb.stable && pend_mid
                    && (since_rise >= TIME_W'(valid_high_reg)))
                begin
                    latch_next      = 1'b1;
                    lock_until_next = now_reg + TIME_W'(lockout_reg);
                    pending_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg         <= TIME_W'(1);
            last_sample_reg <= '0;
            rise_time_reg   <= '0;
            lock_until_reg  <= '0;
            ready_reg       <= 1'b0;
            armed_reg       <= 1'b0;
            latch_reg       <= 1'b0;
            pending_reg     <= 1'b0;
        end
        else
        begin
            now_reg         <= now_next;
            last_sample_reg <= last_sample_next;
            rise_time_reg   <= rise_time_next;
            lock_until_reg  <= lock_until_next;
            ready_reg       <= ready_next;
            armed_reg       <= armed_next;
            latch_reg       <= latch_next;
            pending_reg     <= pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg         <= PERIOD_RST;
            stable_samples_reg <= STABLE_RST;
            startup_reg        <= STARTUP_RST;
            valid_high_reg     <= HIGH_RST;
            lockout_reg        <= LOCKOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_PERIOD:  period_reg         <= cfg_data[PERIOD_W-1:0];
                CFG_STABLE_SAMPLES: stable_samples_reg <= cfg_data[STABLE_W-1:0];
                CFG_STARTUP_IGNORE: startup_reg        <= cfg_data[WIN_W-1:0];
                CFG_VALID_HIGH:     valid_high_reg     <= cfg_data[HIGH_W-1:0];
                CFG_LOCKOUT:        lockout_reg        <= cfg_data[WIN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_ready_reg <= ready_next;
            filtered_reg <= ready_next && deb.stable;
            event_reg    <= event_now;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_ready       = is_ready_reg;
    assign filtered_level = filtered_reg;
    assign motion_event   = event_reg;

endmodule

@@ hw/rtl/pmq_checker.sv @@
`include "pir_motion_qualifier_assert.svh"

module pmq_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic is_ready,
    input logic filtered_level,
    input logic motion_event
);

    // an empty or draining result stage never blocks the input
    `PMQ_ASSERT_NOW(a_ready_when_free, !out_valid || out_ready, in_ready, "input blocked with free output")

    // every taken word yields a result word
    `PMQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "result word missing")

    // the filtered level is forced low before the start-up window ends
    `PMQ_ASSERT_NOW(a_level_needs_ready, out_valid && filtered_level, is_ready, "level high while not ready")

    // once ready, the block stays ready
    `PMQ_ASSERT_NEXT(a_ready_sticky, out_valid && out_ready && is_ready, !out_valid || is_ready, "ready dropped")

    // a stalled word holds
    `PMQ_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(is_ready) && $stable(filtered_level) && $stable(motion_event), "stalled word changed")

endmodule

bind pir_motion_qualifier pmq_checker u_pmq_checker (.*);

@@ test/tb_pir_motion_qualifier.sv @@
module tb_pir_motion_qualifier;
    import pmq_pkg::*;

    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned LONG_HOLD = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);

    typedef struct packed {
        logic action;
        logic pin;
    } sensor_word_t;

    typedef struct packed {
        logic ready;
        logic level;
        logic motion;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = ACT_TICK;
    logic pin_level = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic is_ready;
    logic filtered_level;
    logic motion_event;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pir_motion_qualifier DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .pin_level      (pin_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .is_ready       (is_ready),
        .filtered_level (filtered_level),
        .motion_event   (motion_event),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predicted qualifier state and register copies
    logic [PERIOD_W-1:0] period_cfg;
    logic [STABLE_W-1:0] stable_cfg;
    logic [WIN_W-1:0]    startup_cfg;
    logic [HIGH_W-1:0]   high_cfg;
    logic [WIN_W-1:0]    lockout_cfg;
    logic [TIME_W-1:0]   ms_now;
    logic [TIME_W-1:0]   last_sample;
    logic [TIME_W-1:0]   rise_at;
    logic [TIME_W-1:0]   lock_end;
    logic [STABLE_W-1:0] same_count;
    logic prev_pin;
    logic debounced;
    logic window_done;
    logic armed;
    logic motion_latch;
    logic rise_seen;

    sensor_word_t word_q[$];
    outcome_t     outcome_q[$];
    int unsigned  words_issued = 0;
    int unsigned  results_seen = 0;
    int unsigned  errors = 0;
    int unsigned  idle_cycles = 0;

    task automatic clear_qualifier();
        period_cfg = PERIOD_RST;
        stable_cfg = STABLE_RST;
        startup_cfg = STARTUP_RST;
        high_cfg = HIGH_RST;
        lockout_cfg = LOCKOUT_RST;
        ms_now = '0;
        last_sample = '0;
        rise_at = '0;
        lock_end = '0;
        same_count = STABLE_RST;
        prev_pin = 1'b0;
        debounced = 1'b0;
        window_done = 1'b0;
        armed = 1'b0;
        motion_latch = 1'b0;
        rise_seen = 1'b0;
    endtask

    function automatic void advance_ms(input logic pin);
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] lock_diff;
        logic changed;
        changed = 1'b0;
        ms_now = ms_now + 32'd1;
        now = ms_now;
        if ((now - last_sample) < 32'(period_cfg))
            return;
        last_sample = now;

        if (pin != prev_pin)
        begin
            prev_pin = pin;
            same_count = '0;
        end
        else if (same_count < stable_cfg)
        begin
            same_count = same_count + 8'd1;
            if (same_count >= stable_cfg && debounced != pin)
            begin
                debounced = pin;
                changed = 1'b1;
            end
        end

        if (!window_done)
        begin
            if (now < 32'(startup_cfg))
                return;
            window_done = 1'b1;
            motion_latch = 1'b0;
            rise_seen = 1'b0;
            armed = !debounced;
            return;
        end

        if (!armed)
        begin
            if (!debounced)
                armed = 1'b1;
            return;
        end

        if (changed)
        begin
            if (debounced)
            begin
                rise_at = now;
                rise_seen = 1'b1;
            end
            else
                rise_seen = 1'b0;
        end

        lock_diff = now - lock_end;
        if (lock_diff[TIME_W-1])
            return;

        if (debounced && rise_seen && (now - rise_at) >= 32'(high_cfg))
        begin
            motion_latch = 1'b1;
            lock_end = now + 32'(lockout_cfg);
            rise_seen = 1'b0;
        end
    endfunction

    function automatic outcome_t qualify_word(input logic act, input logic pin);
        outcome_t res;
        res.motion = 1'b0;
        if (act == ACT_CONSUME)
        begin
            res.motion = motion_latch;
            motion_latch = 1'b0;
        end
        else
            advance_ms(pin);
        res.ready = window_done;
        res.level = window_done & debounced;
        return res;
    endfunction

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // sender: bursts of random length, random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    sensor_word_t next_word;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                outcome_q.push_back(qualify_word(action, pin_level));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_q.size() != 0)
                begin
                    next_word = word_q.pop_front();
                    in_valid <= 1'b1;
                    action <= next_word.action;
                    pin_level <= next_word.pin;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall mask, plus one long hold-off
    int unsigned rx_cycle = 0;
    int unsigned hold_left = 0;
    logic long_hold_done = 1'b0;
    logic [15:0] ready_mask = 16'hFFFF;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (!long_hold_done && results_seen >= 150)
            begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (rx_cycle % 32 == 0)
                    ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                             : (16'($urandom) | 16'h0101);
                out_ready <= ready_mask[rx_cycle[3:0]];
            end
        end
    end

    outcome_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (outcome_q.size() == 0)
                report("result word with nothing expected");
            else
            begin
                want = outcome_q.pop_front();
                if (is_ready !== want.ready)
                    report($sformatf("word %0d is_ready got %b want %b",
                                     results_seen, is_ready, want.ready));
                if (filtered_level !== want.level)
                    report($sformatf("word %0d filtered_level got %b want %b",
                                     results_seen, filtered_level, want.level));
                if (motion_event !== want.motion)
                    report($sformatf("word %0d motion_event got %b want %b",
                                     results_seen, motion_event, want.motion));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles == IDLE_LIMIT)
                begin
                    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    task automatic push_word(input logic act, input logic pin);
        sensor_word_t w;
        w.action = act;
        w.pin = pin;
        word_q.push_back(w);
        words_issued++;
    endtask

    task automatic wait_idle();
        while (results_seen < words_issued)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLE_PERIOD:  period_cfg = data[PERIOD_W-1:0];
            CFG_STABLE_SAMPLES: stable_cfg = data[STABLE_W-1:0];
            CFG_STARTUP_IGNORE: startup_cfg = data[WIN_W-1:0];
            CFG_VALID_HIGH:     high_cfg = data[HIGH_W-1:0];
            CFG_LOCKOUT:        lockout_cfg = data[WIN_W-1:0];
            default: ;
        endcase
    endtask

    // level runs with random content; short glitches and stray consumes as noise
    task automatic queue_motion_runs(input int unsigned n, input int unsigned max_run);
        int unsigned left;
        int unsigned run;
        logic lvl;
        left = n;
        while (left > 0)
        begin
            lvl = 1'($urandom_range(0, 1));
            run = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, max_run);
            if (run > left)
                run = left;
            for (int unsigned k = 0; k < run; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                    push_word(ACT_CONSUME, 1'($urandom_range(0, 1)));
                else
                    push_word(ACT_TICK, lvl);
            end
            left -= run;
        end
    endtask

    task automatic run_phase(input int unsigned period, input int unsigned stable,
                             input int unsigned startup, input int unsigned high,
                             input int unsigned lockout, input int unsigned n,
                             input int unsigned max_run);
        wait_idle();
        write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_W'(period));
        write_reg(CFG_STABLE_SAMPLES, CFG_DATA_W'(stable));
        write_reg(CFG_STARTUP_IGNORE, CFG_DATA_W'(startup));
        write_reg(CFG_VALID_HIGH, CFG_DATA_W'(high));
        write_reg(CFG_LOCKOUT, CFG_DATA_W'(lockout));
        queue_motion_runs(n, max_run);
    endtask

    initial
    begin
        clear_qualifier();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: not ready, one sample at ms 10
        push_word(ACT_CONSUME, 1'b0);
        for (int i = 0; i < 10; i++)
            push_word(ACT_TICK, 1'b1);

        wait_idle();
        write_reg(CFG_SAMPLE_PERIOD, 20'hFFC01);
        write_reg(CFG_STABLE_SAMPLES, CFG_DATA_W'(2));
        write_reg(CFG_STARTUP_IGNORE, CFG_DATA_W'(12));
        write_reg(CFG_VALID_HIGH, CFG_DATA_W'(3));
        write_reg(CFG_LOCKOUT, CFG_DATA_W'(6));
        write_reg(CFG_UNUSED, 20'hFFFFF);

        // window ends while high: not armed until a stable low
        push_word(ACT_TICK, 1'b1);
        push_word(ACT_TICK, 1'b1);
        for (int i = 0; i < 3; i++)
            push_word(ACT_TICK, 1'b0);
        for (int i = 0; i < 6; i++)
            push_word(ACT_TICK, 1'b1);
        push_word(ACT_CONSUME, 1'b1);
        push_word(ACT_CONSUME, 1'b0);

        run_phase(1, 1, 0, 2, 5, 60, 8);
        run_phase(0, 2, 100, 3, 12, 60, 10);
        run_phase(2, 8, 1000, 4, 10, 60, 30);
        run_phase(1, 2, 5000, 1, 3, 50, 6);
        run_phase(1, 0, 30000, 0, 0, 40, 6);
        run_phase(1000, 255, 1048575, 65535, 500, 30, 10);
        run_phase(1, 1, 1048575, 65535, 0, 40, 12);
        run_phase(3, 1, 0, 1, 1048575, 60, 15);

        wait_idle();
        repeat (10) @(posedge clk);
        if (outcome_q.size() != 0)
            report($sformatf("%0d expected words never arrived", outcome_q.size()));
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
